// ----- hw/rtl/cbsf_pkg.sv -----
// Shared types and constants of the cat-style byte stream formatter.
`default_nettype none

package cbsf_pkg;

    // Line counter: six decimal digits, saturating at 999999.
    localparam int DIGITS      = 6;
    localparam int DIGIT_IDX_W = 3;

    // The body of one rendered byte is at most four characters ("M-^x").
    localparam int BODY_MAX   = 4;
    localparam int BODY_IDX_W = 2;
    localparam int BODY_LEN_W = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] bcd_digit_t;
    typedef bcd_digit_t [DIGITS-1:0] bcd_count_t;

    localparam bcd_digit_t BCD_NINE  = 4'd9;
    localparam bcd_count_t COUNT_ONE = {{(DIGITS-1){4'd0}}, 4'd1};

    // Character codes.
    localparam byte_t CH_TAB      = 8'h09;
    localparam byte_t CH_NL       = 8'h0A;
    localparam byte_t CH_SPACE    = 8'h20;
    localparam byte_t CH_DOLLAR   = 8'h24;
    localparam byte_t CH_DASH     = 8'h2D;
    localparam byte_t CH_ZERO     = 8'h30;
    localparam byte_t CH_QUESTION = 8'h3F;
    localparam byte_t CH_I        = 8'h49;
    localparam byte_t CH_M        = 8'h4D;
    localparam byte_t CH_CARET    = 8'h5E;
    localparam byte_t CH_DEL      = 8'h7F;

    // Limits and offsets of the caret and M- notation.
    localparam byte_t CTRL_LIMIT   = 8'd32;
    localparam byte_t HIGH_BIT     = 8'd128;
    localparam byte_t HIGH_PRINT   = 8'd160;
    localparam byte_t CARET_OFFSET = 8'd64;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_tabs;
        logic show_ends;
        logic show_nonprinting;
    } cfg_t;

    typedef struct packed {
        logic       after_newline;
        logic       blank_backlog;
        bcd_count_t count;
    } line_state_t;

    // Everything the serializer needs to emit one request's output bytes.
    typedef struct packed {
        logic                  num_en;
        bcd_count_t            digits;
        logic [DIGIT_IDX_W-1:0] num_digits;
        byte_t [BODY_MAX-1:0]  body;
        logic [BODY_LEN_W-1:0] body_len;
    } render_rec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cbsf_render.sv -----
// Line-state update and rendering of one input byte into a compact output record.
`default_nettype none

module cbsf_render (
    input  wire cbsf_pkg::byte_t       data_byte,
    input  wire logic                  file_start,
    input  wire cbsf_pkg::cfg_t        cfg,
    input  wire cbsf_pkg::line_state_t state,
    output cbsf_pkg::line_state_t      state_next,
    output logic                       rec_valid,
    output cbsf_pkg::render_rec_t      rec
);

    // Saturating BCD increment; all nines holds its value.
    function automatic cbsf_pkg::bcd_count_t bcd_sat_inc(input cbsf_pkg::bcd_count_t v);
        cbsf_pkg::bcd_count_t r;
        logic                 carry;
        carry = 1'b1;
        for (int i = 0; i < cbsf_pkg::DIGITS; i++)
        begin
            if (carry && v[i] == cbsf_pkg::BCD_NINE)
            begin
                r[i]  = 4'd0;
            end
            else if (carry)
            begin
                r[i]  = v[i] + 4'd1;
                carry = 1'b0;
            end
            else
            begin
                r[i]  = v[i];
            end
        end
        return carry ? v : r;
    endfunction

    cbsf_pkg::line_state_t eff;
    logic                  nl;
    logic                  squeeze;
    logic                  num_en;
    logic                  nonprint;
    logic [cbsf_pkg::DIGIT_IDX_W-1:0] nd;

    // A file start restores the line state before the byte is looked at.
    always_comb
    begin
        if (file_start)
        begin
            eff.after_newline = 1'b1;
            eff.blank_backlog = 1'b0;
            eff.count         = cbsf_pkg::COUNT_ONE;
        end
        else
        begin
            eff = state;
        end
    end

    assign nl      = (data_byte == cbsf_pkg::CH_NL);
    assign squeeze = eff.after_newline && nl && cfg.squeeze_blank && eff.blank_backlog;
    assign num_en  = eff.after_newline && (cfg.number_nonblank ? !nl : cfg.number_all);

    // Next line state; a squeezed newline leaves it as it is.
    always_comb
    begin
        state_next = eff;
        if (!squeeze)
        begin
            if (eff.after_newline && nl)
            begin
                state_next.blank_backlog = 1'b1;
            end
            else if (!nl)
            begin
                state_next.blank_backlog = 1'b0;
            end
            state_next.after_newline = nl;
            if (num_en)
            begin
                state_next.count = bcd_sat_inc(eff.count);
            end
        end
    end

    // Count of significant digits, at least one.
    always_comb
    begin
        nd = cbsf_pkg::DIGIT_IDX_W'(1);
        for (int i = 1; i < cbsf_pkg::DIGITS; i++)
        begin
            if (eff.count[i] != 4'd0)
            begin
                nd = cbsf_pkg::DIGIT_IDX_W'(i + 1);
            end
        end
    end

    assign nonprint = cfg.show_nonprinting && !nl && (data_byte != cbsf_pkg::CH_TAB) &&
                      ((data_byte >= cbsf_pkg::CH_DEL) || (data_byte < cbsf_pkg::CTRL_LIMIT));

    // Body characters of the byte itself.
    always_comb
    begin
        rec.num_en     = num_en;
        rec.digits     = eff.count;
        rec.num_digits = nd;
        rec.body       = '0;
        rec.body_len   = cbsf_pkg::BODY_LEN_W'(1);
        if (cfg.show_tabs && data_byte == cbsf_pkg::CH_TAB)
        begin
            rec.body[0]  = cbsf_pkg::CH_CARET;
            rec.body[1]  = cbsf_pkg::CH_I;
            rec.body_len = cbsf_pkg::BODY_LEN_W'(2);
        end
        else if (cfg.show_ends && nl)
        begin
            rec.body[0]  = cbsf_pkg::CH_DOLLAR;
            rec.body[1]  = data_byte;
            rec.body_len = cbsf_pkg::BODY_LEN_W'(2);
        end
        else if (nonprint && data_byte == cbsf_pkg::CH_DEL)
        begin
            rec.body[0]  = cbsf_pkg::CH_CARET;
            rec.body[1]  = cbsf_pkg::CH_QUESTION;
            rec.body_len = cbsf_pkg::BODY_LEN_W'(2);
        end
        else if (nonprint && data_byte >= cbsf_pkg::HIGH_PRINT)
        begin
            // Byte 255 comes out as M- followed by a raw DEL.
            rec.body[0]  = cbsf_pkg::CH_M;
            rec.body[1]  = cbsf_pkg::CH_DASH;
            rec.body[2]  = data_byte - cbsf_pkg::HIGH_BIT;
            rec.body_len = cbsf_pkg::BODY_LEN_W'(3);
        end
        else if (nonprint && data_byte >= cbsf_pkg::HIGH_BIT)
        begin
            rec.body[0]  = cbsf_pkg::CH_M;
            rec.body[1]  = cbsf_pkg::CH_DASH;
            rec.body[2]  = cbsf_pkg::CH_CARET;
            rec.body[3]  = data_byte - cbsf_pkg::CARET_OFFSET;
            rec.body_len = cbsf_pkg::BODY_LEN_W'(4);
        end
        else if (nonprint)
        begin
            rec.body[0]  = cbsf_pkg::CH_CARET;
            rec.body[1]  = data_byte + cbsf_pkg::CARET_OFFSET;
            rec.body_len = cbsf_pkg::BODY_LEN_W'(2);
        end
        else
        begin
            rec.body[0]  = data_byte;
        end
    end

    assign rec_valid = !squeeze;

endmodule

`default_nettype wire

// ----- hw/rtl/cbsf_serial.sv -----
// Record register and output serializer: emits one formatted byte per cycle while the receiver is ready.
`default_nettype none

module cbsf_serial #(
    parameter int NUMBER_WIDTH = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire cbsf_pkg::render_rec_t rec_in,
    output logic                       rec_free,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output cbsf_pkg::byte_t            out_byte,
    output logic                       last
);

    localparam int MAXW    = (NUMBER_WIDTH > cbsf_pkg::DIGITS) ? NUMBER_WIDTH : cbsf_pkg::DIGITS;
    localparam int MAX_OUT = MAXW + 1 + cbsf_pkg::BODY_MAX;
    localparam int IDX_W   = $clog2(MAX_OUT + 1);
    localparam logic [IDX_W-1:0] WIDTH_W = IDX_W'(NUMBER_WIDTH);

    logic                  rec_valid_reg;
    cbsf_pkg::render_rec_t rec_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  out_valid_reg;
    cbsf_pkg::byte_t       out_byte_reg;
    logic                  out_last_reg;

    logic [IDX_W-1:0] nd_w;
    logic [IDX_W-1:0] field_len;
    logic [IDX_W-1:0] pad;
    logic [IDX_W-1:0] pfx_len;
    logic [IDX_W-1:0] total;
    logic [IDX_W-1:0] digit_pos;
    logic [IDX_W-1:0] body_pos;
    logic             out_load;
    logic             step;
    logic             final_byte;
    cbsf_pkg::byte_t  sel_byte;

    // Layout of the number prefix: padding, digits, tab.
    assign nd_w      = IDX_W'(rec_reg.num_digits);
    assign field_len = (WIDTH_W > nd_w) ? WIDTH_W : nd_w;
    assign pad       = field_len - nd_w;
    assign pfx_len   = rec_reg.num_en ? field_len + IDX_W'(1) : '0;
    assign total     = pfx_len + IDX_W'(rec_reg.body_len);
    assign digit_pos = pfx_len - IDX_W'(2) - idx_reg;
    assign body_pos  = idx_reg - pfx_len;

    // Character at the current position.
    always_comb
    begin
        if (rec_reg.num_en && idx_reg < pad)
        begin
            sel_byte = cbsf_pkg::CH_SPACE;
        end
        else if (rec_reg.num_en && (idx_reg + IDX_W'(1)) < pfx_len)
        begin
            sel_byte = cbsf_pkg::CH_ZERO +
                       cbsf_pkg::byte_t'(rec_reg.digits[digit_pos[cbsf_pkg::DIGIT_IDX_W-1:0]]);
        end
        else if (rec_reg.num_en && (idx_reg + IDX_W'(1)) == pfx_len)
        begin
            sel_byte = cbsf_pkg::CH_TAB;
        end
        else
        begin
            sel_byte = rec_reg.body[body_pos[cbsf_pkg::BODY_IDX_W-1:0]];
        end
    end

    assign out_load   = !out_valid_reg || out_ready;
    assign step       = rec_valid_reg && out_load;
    assign final_byte = (idx_reg + IDX_W'(1)) == total;
    assign rec_free   = !rec_valid_reg || (step && final_byte);

    // Record register and position counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            rec_valid_reg <= 1'b1;
        end
        else if (step && final_byte)
        begin
            rec_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_in;
            idx_reg <= '0;
        end
        else if (step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= sel_byte;
            out_last_reg <= final_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cat_byte_stream_formatter.sv -----
// Top level of the cat-style byte stream formatter.
//
// Input channel (in_valid/in_ready): one file byte per request, with file_start
// marking the first byte of a new file. Output channel (out_valid/out_ready):
// one formatted byte per request; last marks the final byte caused by an input.
// A newline swallowed by blank-line squeezing produces no output at all.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects one of six
// option bits, cfg_data is its new value; writes are always ready and unknown
// indexes are ignored. Write options only while the block is idle.
//
// The first output byte of an item passes from the record register into the
// output register. Throughput: one output byte per cycle while out_ready is
// high, limited by the single output serializer. An item that renders to n
// bytes (up to five more than the wider of the number field and the six
// counter digits) holds in_ready low until its final byte is registered for
// output; plain bytes flow at one per cycle. A new input is taken while the
// output register still waits on a stalled receiver, as long as the record
// register is free. Reset clears all options, sets the line counter to 1 and
// the line state to "after a newline"; no clearing pass is needed.
`default_nettype none

module cat_byte_stream_formatter #(
    parameter int NUMBER_WIDTH = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              file_start,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [7:0]                             out_byte,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cbsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic                              cfg_data
);

    cbsf_pkg::cfg_t        cfg_reg;
    cbsf_pkg::line_state_t state_reg;
    cbsf_pkg::line_state_t state_next;
    cbsf_pkg::render_rec_t rec;
    logic                  rec_valid;
    logic                  rec_free;
    logic                  in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = rec_free;
    assign in_accept = in_valid && rec_free;

    // Option registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cbsf_pkg::CFG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_data;
                cbsf_pkg::CFG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_data;
                cbsf_pkg::CFG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data;
                cbsf_pkg::CFG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data;
                cbsf_pkg::CFG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data;
                cbsf_pkg::CFG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // Line state advances with every accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.after_newline <= 1'b1;
            state_reg.blank_backlog <= 1'b0;
            state_reg.count         <= cbsf_pkg::COUNT_ONE;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    cbsf_render u_render (
        .data_byte  (data_byte),
        .file_start (file_start),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    cbsf_serial #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept && rec_valid),
        .rec_in    (rec),
        .rec_free  (rec_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/cbsf_checker.sv -----
// Port-level checks of the formatter, bound to the top level.
`default_nettype none

module cbsf_checker #(
    parameter int NUMBER_WIDTH = 6
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last
);

    localparam int MAXW    = (NUMBER_WIDTH > cbsf_pkg::DIGITS) ? NUMBER_WIDTH : cbsf_pkg::DIGITS;
    localparam int MAX_OUT = MAXW + 1 + cbsf_pkg::BODY_MAX;
    localparam int RUN_W   = $clog2(MAX_OUT + 1);
    localparam int PEND_W  = 16;

    logic [RUN_W-1:0]  run_reg;
    logic [PEND_W-1:0] pend_reg;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Bytes of the current item delivered so far, and items still in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (out_acc && last)
            begin
                run_reg <= '0;
            end
            else if (out_acc && run_reg != {RUN_W{1'b1}})
            begin
                run_reg <= run_reg + RUN_W'(1);
            end
            if (pend_reg != {PEND_W{1'b1}})
            begin
                pend_reg <= pend_reg + PEND_W'(in_acc) - PEND_W'(out_acc && last);
            end
        end
    end

    // A stalled output byte holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output byte changed while stalled");

    // No item renders to more bytes than the widest number field, its tab and the longest body.
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !last |-> run_reg < RUN_W'(MAX_OUT - 1))
        else $error("output run exceeds the longest rendering");

    // Every closing byte belongs to an input taken earlier.
    a_last_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && last |-> pend_reg != '0)
        else $error("last byte without a pending input");

endmodule

bind cat_byte_stream_formatter cbsf_checker #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
) u_cbsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
);

`default_nettype wire
